[hw/rtl/chr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types and constants of the consistent hash ring lookup block.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int POS_W     = 10;
  localparam int HASH_W    = 10;
  localparam int MID_W     = 16;
  localparam int OWNER_W   = 16;
  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // slots reachable by a position or a hash code
  localparam int SLOT_LIMIT = 1 << POS_W;

  // occupancy bitmap word
  localparam int WORD_BITS = 32;
  localparam int WORD_LG   = 5;

  localparam logic [REG_W-1:0] RING_SIZE_RST = 11'd1024;
  localparam logic [REG_W-1:0] VNODES_RST    = 11'd3;

  typedef enum logic {
    CMD_PLACE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_SIZE = 1'b0,
    CFG_VNODES    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              cmd;
    logic [POS_W-1:0]  position;
    logic [MID_W-1:0]  mach_id;
    logic [HASH_W-1:0] hashcode;
  } in_item_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic               accepted;
    logic               machine_done;
    logic               ring_empty;
  } out_item_t;

endpackage

[hw/rtl/chr_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chr_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface chr_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[hw/rtl/consistent_hash_ring_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_top
// Place: ST_PCHK checks the bitmap word (skipped when out of range), then
// ST_DONE; a result held by out_ch stalls the input.
// Lookup: ST_SCAN reads one 32-bit occupancy word per cycle from the bitmap
// memory, wrapping past the last of WORDS words (WORDS = 32 at 1024 slots),
// then ST_OWN does one owner memory read; an empty ring goes to ST_DONE.
// Synchronous reset runs a bitmap clearing pass over WORDS words; config is taken.
// ----------------------------------------------------------------------------
module consistent_hash_ring_top #(
  parameter int RING_SLOTS = 1024,
  parameter int ID_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [chr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [chr_pkg::REG_W-1:0]     cfg_wdata,
  chr_stream_if.sink                    in_ch,
  chr_stream_if.source                  out_ch
);

  import chr_pkg::*;

  localparam int LIVE   = (RING_SLOTS < SLOT_LIMIT) ? RING_SLOTS : SLOT_LIMIT;
  localparam int WORDS  = (LIVE + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SLOT_W = $clog2(LIVE);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_PCHK = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_OWN  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [WORD_W-1:0]     clr_r;
  logic [WORD_W-1:0]     cur_r, cur_nxt;
  logic                  first_r, first_nxt;
  logic [WORD_LG-1:0]    hbit_r, hbit_nxt;
  logic [SLOT_W-1:0]     pos_r, pos_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic [REG_W-1:0]      ring_size_r;
  logic [REG_W-1:0]      vnodes_r;
  logic [REG_W-1:0]      placed_r, placed_nxt;
  logic                  any_used_r, any_used_nxt;
  out_item_t             res_r, res_nxt;
  out_item_t             out_r;
  logic                  out_valid_r;

  logic [WORD_BITS-1:0]  used_mem [WORDS];
  logic [ID_BITS-1:0]    own_mem [LIVE];
  logic [WORD_BITS-1:0]  used_rdata;
  logic [ID_BITS-1:0]    own_rdata;
  logic [WORD_W-1:0]     used_ra, used_wa;
  logic [WORD_BITS-1:0]  used_wd;
  logic                  used_we;
  logic [SLOT_W-1:0]     own_ra;
  logic                  own_we;

  logic                  in_fire;
  logic                  out_load;
  logic [SLOT_W-1:0]     in_slot, hash_slot;
  logic                  in_fits, hash_fits;
  logic [WORD_BITS-1:0]  scan_word;
  logic                  hit;
  logic [WORD_LG-1:0]    hit_bit;
  logic [WORD_LG-1:0]    pos_bit;
  logic                  bit_set;
  logic [REG_W-1:0]      cnt_inc, need;

  function automatic logic [WORD_W-1:0] word_of(input logic [SLOT_W-1:0] s);
    word_of = WORD_W'(s >> WORD_LG);
  endfunction

  function automatic logic [WORD_LG-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_LG-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = WORD_LG'(i);
    end
    first_set = r;
  endfunction

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign in_slot   = SLOT_W'(in_ch.data.position);
  assign hash_slot = SLOT_W'(in_ch.data.hashcode);
  assign in_fits   = (17'(in_ch.data.position) < 17'(LIVE)) &&
                     ({1'b0, in_ch.data.position} < ring_size_r);
  assign hash_fits = 17'(in_ch.data.hashcode) < 17'(LIVE);

  assign scan_word = used_rdata & (first_r ? ({WORD_BITS{1'b1}} << hbit_r)
                                           : {WORD_BITS{1'b1}});
  assign hit       = |scan_word;
  assign hit_bit   = first_set(scan_word);
  assign pos_bit   = WORD_LG'(pos_r);
  assign bit_set   = used_rdata[pos_bit];
  assign cnt_inc   = placed_r + 11'd1;
  assign need      = (vnodes_r == '0) ? 11'd1 : vnodes_r;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    first_nxt    = first_r;
    hbit_nxt     = hbit_r;
    pos_nxt      = pos_r;
    id_nxt       = id_r;
    placed_nxt   = placed_r;
    any_used_nxt = any_used_r;
    res_nxt      = res_r;
    used_ra      = cur_r;
    used_we      = 1'b0;
    used_wa      = clr_r;
    used_wd      = '0;
    own_ra       = SLOT_W'({cur_r, hit_bit});
    own_we       = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        used_we = 1'b1;
        if (clr_r == LAST_WORD) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          if (in_ch.data.cmd == CMD_PLACE) begin
            pos_nxt = in_slot;
            id_nxt  = ID_BITS'(in_ch.data.mach_id);
            if (in_fits) begin
              used_ra   = word_of(in_slot);
              state_nxt = ST_PCHK;
            end else begin
              state_nxt = ST_DONE;
            end
          end else if (!any_used_r) begin
            res_nxt.ring_empty = 1'b1;
            state_nxt          = ST_DONE;
          end else begin
            if (hash_fits) begin
              used_ra   = word_of(hash_slot);
              cur_nxt   = word_of(hash_slot);
              first_nxt = 1'b1;
              hbit_nxt  = WORD_LG'(hash_slot);
            end else begin
              used_ra   = '0;
              cur_nxt   = '0;
              first_nxt = 1'b0;
            end
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_PCHK: begin
        if (!bit_set) begin
          used_we          = 1'b1;
          used_wa          = word_of(pos_r);
          used_wd          = used_rdata | (32'd1 << pos_bit);
          own_we           = 1'b1;
          any_used_nxt     = 1'b1;
          res_nxt.accepted = 1'b1;
          if (cnt_inc >= need) begin
            res_nxt.machine_done = 1'b1;
            placed_nxt           = '0;
          end else begin
            placed_nxt = cnt_inc;
          end
        end
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_OWN;
        end else begin
          cur_nxt   = (cur_r == LAST_WORD) ? '0 : cur_r + 1'b1;
          used_ra   = (cur_r == LAST_WORD) ? '0 : cur_r + 1'b1;
          first_nxt = 1'b0;
        end
      end
      ST_OWN: begin
        res_nxt.owner = OWNER_W'(own_rdata);
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // bitmap and owner memories
  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rdata <= used_mem[used_ra];
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[pos_r] <= id_r;
    own_rdata <= own_mem[own_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      placed_r    <= '0;
      any_used_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      placed_r   <= placed_nxt;
      any_used_r <= any_used_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
      vnodes_r    <= VNODES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_RING_SIZE: ring_size_r <= cfg_wdata;
        CFG_VNODES:    vnodes_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    first_r <= first_nxt;
    hbit_r  <= hbit_nxt;
    pos_r   <= pos_nxt;
    id_r    <= id_nxt;
    res_r   <= res_nxt;
    if (out_load) out_r <= res_r;
  end

  a_scan_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> any_used_r)
    else $error("ring scan started with no occupied slot");

  a_place_check_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PCHK) |=> (state_r == ST_DONE))
    else $error("placement check did not finish in one cycle");

  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.accepted && out_r.ring_empty) &&
                    !(out_r.machine_done && !out_r.accepted))
    else $error("inconsistent result flags");

endmodule

[tb/sv/consistent_hash_ring_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_top_test
// Drives place and lookup transactions into the hash ring block. A local
// copy of the ring occupancy, owners and counters predicts every result.
// Results are checked field by field, in order, under random idling on both
// channels. Ring size and virtual node count are swept between phases.
// ----------------------------------------------------------------------------
module consistent_hash_ring_top_test;

  import chr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;
  localparam int IDLE_PCT       = 34;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_wdata;

  chr_stream_if #(.T(in_item_t))  in_ch ();
  chr_stream_if #(.T(out_item_t)) out_ch ();

  consistent_hash_ring_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // ring shadow state
  bit               slot_taken   [SLOT_LIMIT];
  logic [MID_W-1:0] slot_machine [SLOT_LIMIT];
  logic [REG_W-1:0] ring_size_reg;
  logic [REG_W-1:0] vnodes_reg;
  logic [REG_W-1:0] placed_cnt;
  logic [REG_W-1:0] occupied_cnt;

  out_item_t pending_replies[$];
  int        err_count = 0;
  int        stall_cycles = 0;
  bit        steady;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic out_item_t ring_predict(in_item_t it);
    out_item_t        r;
    logic [REG_W:0]   lim;
    logic [REG_W-1:0] need;
    int               hit;
    int               i;
    r = '0;
    if (cmd_t'(it.cmd) == CMD_PLACE) begin
      lim  = (ring_size_reg > SLOT_LIMIT) ? (REG_W+1)'(SLOT_LIMIT) : {1'b0, ring_size_reg};
      need = (vnodes_reg == 0) ? 11'd1 : vnodes_reg;
      if (it.position < lim && !slot_taken[it.position]) begin
        slot_taken[it.position]   = 1'b1;
        slot_machine[it.position] = it.mach_id;
        if (occupied_cnt != '1) occupied_cnt = occupied_cnt + 1'b1;
        r.accepted = 1'b1;
        placed_cnt = placed_cnt + 1'b1;
        if (placed_cnt >= need) begin
          r.machine_done = 1'b1;
          placed_cnt = '0;
        end
      end
    end else if (occupied_cnt == 0) begin
      r.ring_empty = 1'b1;
    end else begin
      hit = -1;
      for (i = it.hashcode; i < SLOT_LIMIT && hit < 0; i++)
        if (slot_taken[i]) hit = i;
      // wrap to the lowest occupied slot
      for (i = 0; i < SLOT_LIMIT && hit < 0; i++)
        if (slot_taken[i]) hit = i;
      if (hit < 0) r.ring_empty = 1'b1;
      else r.owner = slot_machine[hit];
    end
    return r;
  endfunction

  task automatic send_ring_cmd(in_item_t it);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_replies.insert(pending_replies.size(), ring_predict(it));
  endtask

  task automatic place(logic [POS_W-1:0] pos, logic [MID_W-1:0] mid);
    in_item_t it;
    it.cmd        = CMD_PLACE;
    it.position   = pos;
    it.mach_id    = mid;
    it.hashcode   = HASH_W'($urandom);
    send_ring_cmd(it);
  endtask

  task automatic lookup(logic [HASH_W-1:0] hash);
    in_item_t it;
    it.cmd        = CMD_LOOKUP;
    it.position   = POS_W'($urandom);
    it.mach_id    = MID_W'($urandom);
    it.hashcode   = hash;
    send_ring_cmd(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [REG_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RING_SIZE) ring_size_reg = val;
    else vnodes_reg = val;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result transaction: %p", out_ch.data);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.data.owner !== want.owner) begin
          $error("owner: expected %0h, actual %0h", want.owner, out_ch.data.owner);
          err_count++;
        end
        if (out_ch.data.accepted !== want.accepted) begin
          $error("accepted: expected %0b, actual %0b", want.accepted,
                 out_ch.data.accepted);
          err_count++;
        end
        if (out_ch.data.machine_done !== want.machine_done) begin
          $error("machine_done: expected %0b, actual %0b", want.machine_done,
                 out_ch.data.machine_done);
          err_count++;
        end
        if (out_ch.data.ring_empty !== want.ring_empty) begin
          $error("ring_empty: expected %0b, actual %0b", want.ring_empty,
                 out_ch.data.ring_empty);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("consistent_hash_ring_top_test: errors");
      $finish;
    end
  end

  task automatic test_empty_ring();
    lookup('0);
    lookup('1);
  endtask

  task automatic test_place_and_wrap();
    place(10'd0, 16'h0000);
    place(10'd600, 16'hFFFF);
    place(10'd0, 16'h1234);
    place(10'd5, 16'h8001);
    lookup(10'd0);
    lookup(10'd1);
    lookup(10'd600);
    lookup(10'd601);
    lookup(10'd1023);
  endtask

  task automatic test_ring_size_limits();
    cfg_write(CFG_RING_SIZE, 11'd0);
    place(10'd1, 16'h0101);
    cfg_write(CFG_RING_SIZE, 11'd1);
    place(10'd1, 16'h0202);
    place(10'd0, 16'h0303);
    cfg_write(CFG_RING_SIZE, 11'd2047);
    place(10'd1023, 16'hBEEF);
    lookup(10'd1023);
    lookup(10'd700);
    cfg_write(CFG_RING_SIZE, 11'd16);
    place(10'd15, 16'h5A5A);
    place(10'd16, 16'hA5A5);
    lookup(10'd601);
  endtask

  task automatic test_vnode_counts();
    cfg_write(CFG_RING_SIZE, 11'd1024);
    cfg_write(CFG_VNODES, 11'd0);
    place(10'd20, 16'h0014);
    place(10'd21, 16'h0015);
    cfg_write(CFG_VNODES, 11'd5);
    place(10'd22, 16'h0016);
    place(10'd23, 16'h0017);
    place(10'd24, 16'h0018);
    // lowering the count below what is already placed
    cfg_write(CFG_VNODES, 11'd2);
    place(10'd25, 16'h0019);
  endtask

  task automatic run_ring_phase(logic [REG_W-1:0] rsz, logic [REG_W-1:0] vn,
                                int n_items, bit quiet, bit pause_mid);
    in_item_t it;
    int       lim;
    int       k;
    cfg_write(CFG_RING_SIZE, rsz);
    cfg_write(CFG_VNODES, vn);
    lim    = (rsz > SLOT_LIMIT) ? SLOT_LIMIT : rsz;
    steady = quiet;
    for (k = 0; k < n_items; k++) begin
      if (pause_mid && k == n_items / 2) wait_drained();
      it.cmd      = ($urandom_range(0, 99) < 45) ? CMD_LOOKUP : CMD_PLACE;
      it.hashcode = HASH_W'($urandom);
      if (lim > 0 && $urandom_range(0, 99) < 70)
        it.position = POS_W'($urandom_range(0, lim - 1));
      else
        it.position = POS_W'($urandom);
      case ($urandom_range(0, 9))
        0: it.mach_id = '0;
        1: it.mach_id = '1;
        default: it.mach_id = MID_W'($urandom);
      endcase
      send_ring_cmd(it);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_ring_phase(11'd8,    11'd1,    150, 1'b0, 1'b0);
    run_ring_phase(11'd64,   11'd2047, 200, 1'b0, 1'b0);
    run_ring_phase(11'd1,    11'd3,    100, 1'b0, 1'b0);
    run_ring_phase(11'd2047, 11'd0,    200, 1'b1, 1'b0);
    run_ring_phase(11'd300,  11'd7,    250, 1'b0, 1'b0);
    run_ring_phase(11'd0,    11'd2,    100, 1'b0, 1'b0);
    run_ring_phase(11'd1024, 11'd1024, 300, 1'b0, 1'b0);
    run_ring_phase(11'd512,  11'd4,    200, 1'b0, 1'b1);
    run_ring_phase(REG_W'($urandom_range(1, 1024)), REG_W'($urandom_range(0, 2047)),
                   250, 1'b0, 1'b0);
    run_ring_phase(11'd1024, 11'd3,    250, 1'b0, 1'b0);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_RING_SIZE;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    steady        = 1'b0;
    ring_size_reg = RING_SIZE_RST;
    vnodes_reg    = VNODES_RST;
    placed_cnt    = '0;
    occupied_cnt  = '0;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_place_and_wrap();
    test_ring_size_limits();
    test_vnode_counts();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("consistent_hash_ring_top_test: clean");
    else
      $display("consistent_hash_ring_top_test: errors");
    $finish;
  end

endmodule
